>>> rtl/i2c_rts_pkg.sv
package i2c_rts_pkg;

  // Largest data byte count of one transaction.
  localparam int unsigned MaxBytes = 255;

  // Operation codes of an input item.
  localparam logic OpStart = 1'b0;
  localparam logic OpEvent = 1'b1;

  // Start kinds.
  localparam logic KindRead  = 1'b0;
  localparam logic KindWrite = 1'b1;

  // Controller status bits.
  localparam logic [15:0] StBusErr   = 16'h0001;
  localparam logic [15:0] StArbLost  = 16'h0002;
  localparam logic [15:0] StRxNack   = 16'h0004;
  localparam logic [15:0] StLoTout   = 16'h0040;
  localparam logic [15:0] StMExtTout = 16'h0100;
  localparam logic [15:0] StSExtTout = 16'h0200;
  localparam logic [15:0] StLenErr   = 16'h0400;
  localparam logic [15:0] StBusMask  = 16'h0030;
  localparam logic [15:0] StBusBusy  = 16'h0030;

  // Sequencer phases.
  localparam logic [2:0] PhIdle   = 3'd0;
  localparam logic [2:0] PhRegRd  = 3'd1;
  localparam logic [2:0] PhRegWr  = 3'd2;
  localparam logic [2:0] PhRStart = 3'd3;
  localparam logic [2:0] PhSend   = 3'd4;
  localparam logic [2:0] PhRecv   = 3'd5;
  localparam logic [2:0] PhLast   = 3'd6;

  // Result codes.
  localparam logic [1:0] RcOk      = 2'd0;
  localparam logic [1:0] RcBusy    = 2'd1;
  localparam logic [1:0] RcIo      = 2'd2;
  localparam logic [1:0] RcTimeout = 2'd3;

  typedef struct packed {
    logic        operation;
    logic        start_kind;
    logic [6:0]  device_addr;
    logic [7:0]  reg_index;
    logic [7:0]  byte_count;
    logic        master_flag;
    logic        slave_flag;
    logic        error_flag;
    logic [15:0] status_word;
    logic [7:0]  tx_byte;
    logic [7:0]  rx_byte;
  } rts_in_t;

  typedef struct packed {
    logic [1:0] result_code;
    logic       addr_write;
    logic [7:0] addr_value;
    logic       data_write;
    logic [7:0] data_value;
    logic       send_stop;
    logic       tx_taken;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic       done_res;
    logic [2:0] phase;
  } rts_out_t;

  // Maps a nonzero status word to a result code; io errors win, then
  // arbitration loss, then timeouts, else the error flag gives an io error.
  function automatic logic [1:0] error_code(logic [15:0] status, logic err_flag);
    logic [1:0] code;
    code = RcOk;
    if ((status & (StBusErr | StLenErr | StRxNack)) != 16'd0) begin
      code = RcIo;
    end else if ((status & StArbLost) != 16'd0) begin
      code = RcBusy;
    end else if ((status & (StLoTout | StMExtTout | StSExtTout)) != 16'd0) begin
      code = RcTimeout;
    end else if (err_flag) begin
      code = RcIo;
    end
    return code;
  endfunction

endpackage

>>> rtl/i2c_register_transfer_sequencer.sv
// Channel   Valid       Stall        Payload          Direction
// input     in_valid_i  in_stall_o   in_data_i        start commands and controller events
// output    out_valid_o out_stall_i  out_data_o       one result per input item
//
// Every input item yields exactly one result. An item passes through the input register
// and then the result register, which holds the result while the output stalls.
// Unless stalled, one item is accepted per cycle; the sequencer state is one register set
// updated as an item moves from the input register into the result register.
// Reset puts the sequencer in idle with a zero count, address and index.
// A stall on the output holds the result register and, once the input
// register is also full, stalls the input.
module i2c_register_transfer_sequencer
  import i2c_rts_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  rts_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output rts_out_t out_data_o
);

  // Input register.
  logic    in_valid_q;
  rts_in_t in_q;

  // Result register.
  logic     out_valid_q;
  rts_out_t out_q;
  rts_out_t out_d;

  // Sequencer state.
  logic [2:0] phase_q, phase_d;
  logic [7:0] count_q, count_d;
  logic [6:0] addr_q, addr_d;
  logic [7:0] index_q, index_d;

  logic advance;
  logic in_take;

  // The held item moves on when the result register is empty or is being
  // drained in this cycle.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  // Work for one item, following the transaction phase.
  always_comb begin
    logic [7:0] cnt;
    logic [1:0] code;
    logic       any_flag;
    logic [7:0] dec;

    out_d   = '0;
    phase_d = phase_q;
    count_d = count_q;
    addr_d  = addr_q;
    index_d = index_q;
    cnt     = in_q.byte_count;
    code    = RcOk;
    any_flag = in_q.master_flag || in_q.slave_flag || in_q.error_flag;
    dec     = (count_q != 8'd0) ? (count_q - 8'd1) : 8'd0;

    if (in_q.operation == OpStart) begin
      // A start is refused while a transfer runs or the bus is owned.
      if (phase_q != PhIdle || (in_q.status_word & StBusMask) == StBusBusy) begin
        out_d.result_code = RcBusy;
      end else begin
        if ({8'd0, in_q.byte_count} > MaxBytes[15:0]) begin
          cnt = MaxBytes[7:0];
        end
        count_d = cnt;
        addr_d  = in_q.device_addr;
        index_d = in_q.reg_index;
        phase_d = (in_q.start_kind == KindWrite) ? PhRegWr : PhRegRd;
        out_d.addr_write = 1'b1;
        out_d.addr_value = {in_q.device_addr, 1'b0};
      end
    end else if (any_flag && phase_q != PhIdle) begin
      if (in_q.status_word != 16'd0) begin
        code = error_code(in_q.status_word, in_q.error_flag);
      end
      if (code != RcOk) begin
        out_d.send_stop   = 1'b1;
        out_d.done_res    = 1'b1;
        out_d.result_code = code;
        phase_d           = PhIdle;
      end else if (in_q.master_flag) begin
        unique case (phase_q)
          PhRegRd: begin
            out_d.data_write = 1'b1;
            out_d.data_value = index_q;
            // A zero-length read ends right after the register index.
            if (count_q == 8'd0) begin
              out_d.send_stop = 1'b1;
              out_d.done_res  = 1'b1;
              phase_d         = PhIdle;
            end else begin
              phase_d = PhRStart;
            end
          end
          PhRegWr: begin
            out_d.data_write = 1'b1;
            out_d.data_value = index_q;
            phase_d = (count_q != 8'd0) ? PhSend : PhLast;
          end
          PhRStart: begin
            out_d.addr_write = 1'b1;
            out_d.addr_value = {addr_q, 1'b1};
            phase_d = PhRecv;
          end
          PhSend: begin
            out_d.data_write = 1'b1;
            out_d.data_value = in_q.tx_byte;
            out_d.tx_taken   = 1'b1;
            count_d = dec;
            phase_d = (dec != 8'd0) ? PhSend : PhLast;
          end
          PhLast: begin
            out_d.send_stop = 1'b1;
            out_d.done_res  = 1'b1;
            phase_d         = PhIdle;
          end
          default: begin
            // A master event while receiving is a protocol slip.
            out_d.send_stop   = 1'b1;
            out_d.done_res    = 1'b1;
            out_d.result_code = RcIo;
            phase_d           = PhIdle;
          end
        endcase
      end else if (in_q.slave_flag) begin
        if (phase_q == PhRecv) begin
          // The stop goes out together with the last byte read.
          if (count_q <= 8'd1) begin
            out_d.send_stop = 1'b1;
          end
          out_d.rx_valid = 1'b1;
          out_d.rx_data  = in_q.rx_byte;
          count_d = dec;
          if (dec == 8'd0) begin
            out_d.send_stop = 1'b1;
            out_d.done_res  = 1'b1;
            phase_d         = PhIdle;
          end
        end else begin
          out_d.send_stop   = 1'b1;
          out_d.done_res    = 1'b1;
          out_d.result_code = RcIo;
          phase_d           = PhIdle;
        end
      end
    end

    out_d.phase = phase_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PhIdle;
      count_q     <= 8'd0;
      addr_q      <= 7'd0;
      index_q     <= 8'd0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        phase_q     <= phase_d;
        count_q     <= count_d;
        addr_q      <= addr_d;
        index_q     <= index_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  // A finished transfer always leaves the sequencer idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.done_res |-> out_data_o.phase == PhIdle)
    else $error("done without returning to idle");

  // Every stop ends the transfer.
  a_stop_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.send_stop |-> out_data_o.done_res)
    else $error("stop issued without finishing");

  // The sequencer state only moves when an item is processed.
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(phase_q) && $stable(count_q))
    else $error("state changed without an item");

  // The input is stalled only while an item waits in the input register.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled without a waiting item");
`endif

endmodule
